### hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/adx_pkg.sv
// shared constants of the directional index block
package adx_pkg;
  localparam int unsigned SUM_W             = 64;
  localparam int unsigned PER_W             = 8;
  localparam logic [PER_W-1:0] PERIOD_RESET = 8'd14;
  localparam int unsigned DEF_PRICE_BITS    = 32;
  localparam int unsigned DEF_FRACTION_BITS = 16;
  localparam int unsigned DEF_MAX_PERIOD    = 255;
endpackage

### hdl/adx_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module adx_div #(
  parameter int unsigned DIV_W  = 87,
  parameter int unsigned DEN_W  = 64,
  parameter int unsigned STEP_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);
  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DIV_W-1:0]  dvd_r, q_r;
  logic [DEN_W-1:0]  den_r, rem_r;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  // dividend is left aligned, its msb enters the remainder each step
  assign rem_sh = {rem_r, dvd_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

`include "assert_macros.svh"
  `ASSERT_IMP(a_start_idle, clk, rst_n, start, !busy_r)
  `ASSERT_NEXT(a_last_step, clk, rst_n, busy_r && !start && cnt_r == STEP_W'(1), done_r && !busy_r)
  `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)
endmodule

### hdl/average_directional_index.sv
// Wilder average directional index over a stream of price bars.
// Each accepted bar gives one result with +DI, -DI, DX and ADX (unsigned, FRACTION_BITS
// fraction bits, 0..100) and their valid flags. One bar is worked on at a time on a
// single bit-serial divider. It runs SUM_W steps for each of the three smoothing
// divisions after the seed, SUM_W+7+FRACTION_BITS steps for each DI or DX ratio unless
// it saturates, and FRACTION_BITS+16 steps for the ADX division. The first bar and
// any bar with period zero need no division. A new bar may be taken while the
// previous result still waits on the output.
module average_directional_index import adx_pkg::*; #(
  parameter int unsigned PRICE_BITS    = DEF_PRICE_BITS,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int unsigned MAX_PERIOD    = DEF_MAX_PERIOD
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [PER_W-1:0]         cfg_smoothing_period,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [PRICE_BITS-1:0]    in_high_price,
  input  logic [PRICE_BITS-1:0]    in_low_price,
  input  logic [PRICE_BITS-1:0]    in_close_price,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRACTION_BITS+6:0] out_plus_di,
  output logic [FRACTION_BITS+6:0] out_minus_di,
  output logic [FRACTION_BITS+6:0] out_dx_value,
  output logic [FRACTION_BITS+6:0] out_adx_value,
  output logic                     out_di_valid,
  output logic                     out_dx_valid,
  output logic                     out_adx_valid
);
  localparam int unsigned PB        = PRICE_BITS;
  localparam int unsigned OUT_W     = FRACTION_BITS + 7;
  // the running adx may pass 100 when the period changes during seeding
  localparam int unsigned ADX_W     = OUT_W + 1;
  localparam int unsigned BARS_CAP  = 2 * MAX_PERIOD + 1;
  localparam int unsigned CNT_W     = $clog2(BARS_CAP + 1);
  localparam int unsigned CMP_W     = (CNT_W > PER_W ? CNT_W : PER_W) + 2;
  localparam int unsigned SEED_W    = ADX_W + PER_W;
  localparam int unsigned ADXN_W    = ADX_W + PER_W;
  localparam int unsigned RAT_W     = SUM_W + 7;
  localparam int unsigned DIV_W     = RAT_W + FRACTION_BITS;
  localparam int unsigned STEP_W    = $clog2(DIV_W + 1);
  localparam logic [OUT_W-1:0] FULL = OUT_W'(100) << FRACTION_BITS;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_PREP   = 5'd1;
  localparam logic [4:0] ST_SMOOTH = 5'd2;
  localparam logic [4:0] ST_DR_GO  = 5'd3;
  localparam logic [4:0] ST_DR_W   = 5'd4;
  localparam logic [4:0] ST_DU_GO  = 5'd5;
  localparam logic [4:0] ST_DU_W   = 5'd6;
  localparam logic [4:0] ST_DD_GO  = 5'd7;
  localparam logic [4:0] ST_DD_W   = 5'd8;
  localparam logic [4:0] ST_CHECK  = 5'd9;
  localparam logic [4:0] ST_PDI_GO = 5'd10;
  localparam logic [4:0] ST_PDI_W  = 5'd11;
  localparam logic [4:0] ST_MDI_GO = 5'd12;
  localparam logic [4:0] ST_MDI_W  = 5'd13;
  localparam logic [4:0] ST_DX_GO  = 5'd14;
  localparam logic [4:0] ST_DX_W   = 5'd15;
  localparam logic [4:0] ST_ADX    = 5'd16;
  localparam logic [4:0] ST_SEED_GO = 5'd17;
  localparam logic [4:0] ST_SEED_W = 5'd18;
  localparam logic [4:0] ST_AVG_GO = 5'd19;
  localparam logic [4:0] ST_AVG_W  = 5'd20;
  localparam logic [4:0] ST_FIN    = 5'd21;

  logic [4:0]        state_r;
  logic [PER_W-1:0]  cfg_r, p_r;
  logic [PB-1:0]     ph_r, pl_r, pc_r, h_r, l_r, c_r;
  logic [PB-1:0]     tr_r, pdm_r, mdm_r;
  logic [CNT_W-1:0]  bars_r, i_r;
  logic [SUM_W-1:0]  rs_r, us_r, ds_r;
  logic [SEED_W-1:0] seed_r;
  logic [ADX_W-1:0]  adx_r;
  logic [OUT_W-1:0]  pdi_r, mdi_r, dx_r;
  logic [ADXN_W-1:0] prod_r;
  logic              poison_r, div_r, dxv_r, adxv_r;
  logic              out_valid_r, out_div_r, out_dxv_r, out_adxv_r;
  logic [OUT_W-1:0]  out_pdi_r, out_mdi_r, out_dx_r, out_adx_r;

  // bar terms
  logic signed [PB:0] up_s, down_s;
  logic [PB-1:0]      hl, t2, t3, tr12, tr_nxt, pdm_nxt, mdm_nxt;
  assign up_s   = $signed({1'b0, h_r}) - $signed({1'b0, ph_r});
  assign down_s = $signed({1'b0, pl_r}) - $signed({1'b0, l_r});
  assign hl     = (h_r >= l_r) ? h_r - l_r : '0;
  assign t2     = (h_r >= pc_r) ? h_r - pc_r : pc_r - h_r;
  assign t3     = (l_r >= pc_r) ? l_r - pc_r : pc_r - l_r;
  assign tr12   = (t2 > hl) ? t2 : hl;
  assign tr_nxt = (t3 > tr12) ? t3 : tr12;
  assign pdm_nxt = (up_s > down_s && up_s > 0) ? up_s[PB-1:0] : '0;
  assign mdm_nxt = (down_s > up_s && down_s > 0) ? down_s[PB-1:0] : '0;

  logic [CMP_W-1:0] iw, pw, p2;
  assign iw = CMP_W'(i_r);
  assign pw = CMP_W'(p_r);
  assign p2 = pw << 1;

  logic [OUT_W:0]   dsum;
  logic [OUT_W-1:0] ddiff;
  assign dsum  = {1'b0, pdi_r} + {1'b0, mdi_r};
  assign ddiff = (pdi_r >= mdi_r) ? pdi_r - mdi_r : mdi_r - pdi_r;

  // divider request
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dvd, div_q;
  logic [SUM_W-1:0]  div_den, rat_num;
  logic [STEP_W-1:0] div_steps;
  logic [RAT_W-1:0]  num100;
  logic [ADXN_W-1:0] avg_num;

  assign num100  = (RAT_W'(rat_num) << 6) + (RAT_W'(rat_num) << 5) + (RAT_W'(rat_num) << 2);
  assign avg_num = prod_r + ADXN_W'(dx_r);

  always_comb begin
    div_start = 1'b0;
    rat_num   = us_r;
    div_den   = SUM_W'(p_r);
    div_dvd   = {rs_r, {(DIV_W-SUM_W){1'b0}}};
    div_steps = STEP_W'(SUM_W);
    case (state_r)
      ST_DR_GO: div_start = 1'b1;
      ST_DU_GO: begin
        div_start = 1'b1;
        div_dvd   = {us_r, {(DIV_W-SUM_W){1'b0}}};
      end
      ST_DD_GO: begin
        div_start = 1'b1;
        div_dvd   = {ds_r, {(DIV_W-SUM_W){1'b0}}};
      end
      ST_PDI_GO, ST_MDI_GO, ST_DX_GO: begin
        if (state_r == ST_PDI_GO) begin
          rat_num   = us_r;
          div_den   = rs_r;
          div_start = us_r < rs_r;
        end else if (state_r == ST_MDI_GO) begin
          rat_num   = ds_r;
          div_den   = rs_r;
          div_start = ds_r < rs_r;
        end else begin
          rat_num   = SUM_W'(ddiff);
          div_den   = SUM_W'(dsum);
          div_start = (dsum != '0) && ((OUT_W+1)'(ddiff) < dsum);
        end
        div_dvd   = {num100, {FRACTION_BITS{1'b0}}};
        div_steps = STEP_W'(DIV_W);
      end
      ST_SEED_GO: begin
        div_start = 1'b1;
        div_dvd   = {seed_r, {(DIV_W-SEED_W){1'b0}}};
        div_steps = STEP_W'(SEED_W);
      end
      ST_AVG_GO: begin
        div_start = 1'b1;
        div_dvd   = {avg_num, {(DIV_W-ADXN_W){1'b0}}};
        div_steps = STEP_W'(ADXN_W);
      end
      default: div_start = 1'b0;
    endcase
  end

  adx_div #(
    .DIV_W (DIV_W),
    .DEN_W (SUM_W),
    .STEP_W(STEP_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_den),
    .steps   (div_steps),
    .done    (div_done),
    .quotient(div_q)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= PERIOD_RESET;
      ph_r        <= '0;
      pl_r        <= '0;
      pc_r        <= '0;
      bars_r      <= '0;
      rs_r        <= '0;
      us_r        <= '0;
      ds_r        <= '0;
      seed_r      <= '0;
      adx_r       <= '0;
      poison_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= (32'(cfg_smoothing_period) > MAX_PERIOD) ? PER_W'(MAX_PERIOD)
                                                           : cfg_smoothing_period;
      end
      if (out_valid_r && out_ready && state_r != ST_FIN) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            h_r    <= in_high_price;
            l_r    <= in_low_price;
            c_r    <= in_close_price;
            p_r    <= cfg_r;
            i_r    <= bars_r;
            div_r  <= 1'b0;
            dxv_r  <= 1'b0;
            adxv_r <= 1'b0;
            pdi_r  <= '0;
            mdi_r  <= '0;
            dx_r   <= '0;
            if (bars_r != CNT_W'(BARS_CAP)) bars_r <= bars_r + CNT_W'(1);
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          tr_r  <= tr_nxt;
          pdm_r <= pdm_nxt;
          mdm_r <= mdm_nxt;
          ph_r  <= h_r;
          pl_r  <= l_r;
          pc_r  <= c_r;
          state_r <= (i_r == '0 || p_r == '0) ? ST_FIN : ST_SMOOTH;
        end
        ST_SMOOTH: begin
          if (iw <= pw) begin
            rs_r <= rs_r + SUM_W'(tr_r);
            us_r <= us_r + SUM_W'(pdm_r);
            ds_r <= ds_r + SUM_W'(mdm_r);
            state_r <= ST_CHECK;
          end else begin
            state_r <= ST_DR_GO;
          end
        end
        ST_DR_GO: state_r <= ST_DR_W;
        ST_DR_W: if (div_done) begin
          rs_r <= rs_r - div_q[SUM_W-1:0] + SUM_W'(tr_r);
          state_r <= ST_DU_GO;
        end
        ST_DU_GO: state_r <= ST_DU_W;
        ST_DU_W: if (div_done) begin
          us_r <= us_r - div_q[SUM_W-1:0] + SUM_W'(pdm_r);
          state_r <= ST_DD_GO;
        end
        ST_DD_GO: state_r <= ST_DD_W;
        ST_DD_W: if (div_done) begin
          ds_r <= ds_r - div_q[SUM_W-1:0] + SUM_W'(mdm_r);
          state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          if (iw < pw) begin
            state_r <= ST_FIN;
          end else if (rs_r != '0) begin
            div_r   <= 1'b1;
            state_r <= ST_PDI_GO;
          end else begin
            state_r <= ST_ADX;
          end
        end
        ST_PDI_GO: begin
          if (div_start) begin
            state_r <= ST_PDI_W;
          end else begin
            pdi_r   <= FULL;
            state_r <= ST_MDI_GO;
          end
        end
        ST_PDI_W: if (div_done) begin
          pdi_r   <= div_q[OUT_W-1:0];
          state_r <= ST_MDI_GO;
        end
        ST_MDI_GO: begin
          if (div_start) begin
            state_r <= ST_MDI_W;
          end else begin
            mdi_r   <= FULL;
            state_r <= ST_DX_GO;
          end
        end
        ST_MDI_W: if (div_done) begin
          mdi_r   <= div_q[OUT_W-1:0];
          state_r <= ST_DX_GO;
        end
        ST_DX_GO: begin
          if (dsum == '0) begin
            state_r <= ST_ADX;
          end else begin
            dxv_r <= 1'b1;
            if (div_start) begin
              state_r <= ST_DX_W;
            end else begin
              dx_r    <= FULL;
              state_r <= ST_ADX;
            end
          end
        end
        ST_DX_W: if (div_done) begin
          dx_r    <= div_q[OUT_W-1:0];
          state_r <= ST_ADX;
        end
        ST_ADX: begin
          if (iw < p2) begin
            // still seeding: invalid dx is left out of the sum
            if (dxv_r) seed_r <= seed_r + SEED_W'(dx_r);
            state_r <= (iw == p2 - CMP_W'(1)) ? ST_SEED_GO : ST_FIN;
          end else if (poison_r || !dxv_r) begin
            poison_r <= 1'b1;
            state_r  <= ST_FIN;
          end else begin
            prod_r  <= ADXN_W'(adx_r) * ADXN_W'(p_r - PER_W'(1));
            state_r <= ST_AVG_GO;
          end
        end
        ST_SEED_GO: state_r <= ST_SEED_W;
        ST_SEED_W: if (div_done) begin
          adx_r   <= div_q[ADX_W-1:0];
          adxv_r  <= !poison_r;
          state_r <= ST_FIN;
        end
        ST_AVG_GO: state_r <= ST_AVG_W;
        ST_AVG_W: if (div_done) begin
          adx_r   <= div_q[ADX_W-1:0];
          adxv_r  <= 1'b1;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && (!out_valid_r || out_ready)) begin
      out_pdi_r  <= pdi_r;
      out_mdi_r  <= mdi_r;
      out_dx_r   <= dx_r;
      out_adx_r  <= adxv_r ? adx_r[OUT_W-1:0] : '0;
      out_div_r  <= div_r;
      out_dxv_r  <= dxv_r;
      out_adxv_r <= adxv_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_plus_di   = out_pdi_r;
  assign out_minus_di  = out_mdi_r;
  assign out_dx_value  = out_dx_r;
  assign out_adx_value = out_adx_r;
  assign out_di_valid  = out_div_r;
  assign out_dx_valid  = out_dxv_r;
  assign out_adx_valid = out_adxv_r;

`include "assert_macros.svh"
  `ASSERT_IMP(a_dx_needs_di, clk, rst_n, out_valid_r && out_dxv_r, out_div_r)
  `ASSERT_IMP(a_di_bound, clk, rst_n, out_valid_r, out_pdi_r <= FULL && out_mdi_r <= FULL)
  `ASSERT_IMP(a_bars_cap, clk, rst_n, 1'b1, bars_r <= CNT_W'(BARS_CAP))
endmodule
